// ===== hdl/rtcr_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcr_pkg: shared types and constants for the rotated text cell mapper
// widths, register indexes, orientation codes and the derived grid word
// ----------------------------------------------------------------------------
package rtcr_pkg;

    localparam int COORD_BITS    = 12;
    localparam int IDX_BITS      = 12;
    localparam int SIZE_BITS     = 8;
    localparam int ORIENT_BITS   = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int CMP_BITS      = (COORD_BITS > IDX_BITS) ? COORD_BITS : IDX_BITS;
    localparam int PROD_BITS     = IDX_BITS + SIZE_BITS;
    localparam int DIV_CNT_BITS  = $clog2(COORD_BITS + 1);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [SIZE_BITS-1:0]  size_t;
    typedef logic [PROD_BITS-1:0]  prod_t;

    localparam size_t CELL_WIDTH_RESET  = SIZE_BITS'(8);
    localparam size_t CELL_HEIGHT_RESET = SIZE_BITS'(16);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BOUND_LEFT   = 3'd0,
        REG_BOUND_TOP    = 3'd1,
        REG_BOUND_RIGHT  = 3'd2,
        REG_BOUND_BOTTOM = 3'd3,
        REG_CELL_WIDTH   = 3'd4,
        REG_CELL_HEIGHT  = 3'd5,
        REG_ORIENTATION  = 3'd6
    } cfg_reg_t;

    typedef enum logic [ORIENT_BITS-1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } orient_t;

    // grid geometry derived from the configuration, seen by the datapath
    typedef struct packed {
        coord_t cols;
        coord_t rows;
        coord_t base_x;
        coord_t base_y;
        size_t  step_x;
        size_t  step_y;
        logic   swap;
        logic   flip_x;
        logic   flip_y;
    } grid_t;

endpackage

// ===== hdl/rtcr_div.sv =====
// ----------------------------------------------------------------------------
// rtcr_div: restoring divider, one quotient bit per cycle
// divides a coordinate extent by a cell size, gives quotient and remainder
// ----------------------------------------------------------------------------
module rtcr_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  rtcr_pkg::coord_t        dividend,
    input  rtcr_pkg::size_t         divisor,
    output logic                    busy,
    output rtcr_pkg::coord_t        quotient,
    output rtcr_pkg::size_t         remainder
);

    logic [rtcr_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    rtcr_pkg::coord_t                  quo_reg;
    rtcr_pkg::size_t                   rem_reg;
    logic [rtcr_pkg::SIZE_BITS:0]      shifted;
    logic [rtcr_pkg::SIZE_BITS:0]      trial;
    logic                              fits;

    assign shifted = {rem_reg, quo_reg[rtcr_pkg::COORD_BITS-1]};
    assign trial   = shifted - {1'b0, divisor};
    assign fits    = shifted >= {1'b0, divisor};
    assign busy    = cnt_reg != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= rtcr_pkg::DIV_CNT_BITS'(rtcr_pkg::COORD_BITS);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy)
        begin
            quo_reg <= {quo_reg[rtcr_pkg::COORD_BITS-2:0], fits};
            rem_reg <= fits ? trial[rtcr_pkg::SIZE_BITS-1:0]
                            : shifted[rtcr_pkg::SIZE_BITS-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/rtcr_cfg.sv =====
// ----------------------------------------------------------------------------
// rtcr_cfg: configuration registers and grid geometry unit
// holds the registers and derives counts, pads and corner bases after reset and writes
// ----------------------------------------------------------------------------
module rtcr_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [rtcr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [rtcr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output rtcr_pkg::grid_t                       grid,
    output logic                                  busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t            state_reg;
    rtcr_pkg::grid_t   grid_reg;

    rtcr_pkg::coord_t  left_reg;
    rtcr_pkg::coord_t  top_reg;
    rtcr_pkg::coord_t  right_reg;
    rtcr_pkg::coord_t  bottom_reg;
    rtcr_pkg::size_t   cw_reg;
    rtcr_pkg::size_t   ch_reg;
    rtcr_pkg::orient_t orient_reg;

    logic              odd;
    rtcr_pkg::coord_t  ext_w;
    rtcr_pkg::coord_t  ext_h;
    rtcr_pkg::coord_t  log_w;
    rtcr_pkg::coord_t  log_h;
    logic              div_w_busy;
    logic              div_h_busy;
    rtcr_pkg::coord_t  quo_w;
    rtcr_pkg::coord_t  quo_h;
    rtcr_pkg::size_t   rem_w;
    rtcr_pkg::size_t   rem_h;
    rtcr_pkg::coord_t  left_w;
    rtcr_pkg::coord_t  left_h;
    rtcr_pkg::coord_t  pad_x;
    rtcr_pkg::coord_t  pad_y;
    rtcr_pkg::coord_t  pad_bx;
    rtcr_pkg::coord_t  pad_by;
    rtcr_pkg::grid_t   grid_next;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            cw_reg     <= rtcr_pkg::CELL_WIDTH_RESET;
            ch_reg     <= rtcr_pkg::CELL_HEIGHT_RESET;
            orient_reg <= rtcr_pkg::ROT_0;
        end
        else if (cfg_write)
        begin
            unique case (rtcr_pkg::cfg_reg_t'(cfg_index))
                rtcr_pkg::REG_BOUND_LEFT:   left_reg   <= cfg_data[rtcr_pkg::COORD_BITS-1:0];
                rtcr_pkg::REG_BOUND_TOP:    top_reg    <= cfg_data[rtcr_pkg::COORD_BITS-1:0];
                rtcr_pkg::REG_BOUND_RIGHT:  right_reg  <= cfg_data[rtcr_pkg::COORD_BITS-1:0];
                rtcr_pkg::REG_BOUND_BOTTOM: bottom_reg <= cfg_data[rtcr_pkg::COORD_BITS-1:0];
                rtcr_pkg::REG_CELL_WIDTH:   cw_reg     <= cfg_data[rtcr_pkg::SIZE_BITS-1:0];
                rtcr_pkg::REG_CELL_HEIGHT:  ch_reg     <= cfg_data[rtcr_pkg::SIZE_BITS-1:0];
                rtcr_pkg::REG_ORIENTATION:
                    orient_reg <= rtcr_pkg::orient_t'(cfg_data[rtcr_pkg::ORIENT_BITS-1:0]);
                default: ;
            endcase
        end
    end

    // extents clamped at zero, swapped for quarter turns
    assign odd   = orient_reg[0];
    assign ext_w = (right_reg > left_reg) ? right_reg - left_reg : '0;
    assign ext_h = (bottom_reg > top_reg) ? bottom_reg - top_reg : '0;
    assign log_w = odd ? ext_h : ext_w;
    assign log_h = odd ? ext_w : ext_h;

    rtcr_div u_div_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == ST_LOAD),
        .dividend  (log_w),
        .divisor   (cw_reg),
        .busy      (div_w_busy),
        .quotient  (quo_w),
        .remainder (rem_w)
    );

    rtcr_div u_div_h (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == ST_LOAD),
        .dividend  (log_h),
        .divisor   (ch_reg),
        .busy      (div_h_busy),
        .quotient  (quo_h),
        .remainder (rem_h)
    );

    // zero cell size: no cells, whole extent is leftover
    always_comb
    begin
        left_w = (cw_reg == '0) ? log_w : rtcr_pkg::COORD_BITS'(rem_w);
        left_h = (ch_reg == '0) ? log_h : rtcr_pkg::COORD_BITS'(rem_h);
        pad_x  = left_w >> 1;
        pad_y  = left_h >> 1;
        pad_bx = odd ? pad_y : pad_x;
        pad_by = odd ? pad_x : pad_y;

        grid_next.cols   = (cw_reg == '0) ? '0 : quo_w;
        grid_next.rows   = (ch_reg == '0) ? '0 : quo_h;
        grid_next.swap   = odd;
        grid_next.flip_x = (orient_reg == rtcr_pkg::ROT_180) ||
                           (orient_reg == rtcr_pkg::ROT_270);
        grid_next.flip_y = (orient_reg == rtcr_pkg::ROT_90) ||
                           (orient_reg == rtcr_pkg::ROT_180);
        grid_next.step_x = odd ? ch_reg : cw_reg;
        grid_next.step_y = odd ? cw_reg : ch_reg;
        grid_next.base_x = grid_next.flip_x ? right_reg - pad_bx : left_reg + pad_bx;
        grid_next.base_y = grid_next.flip_y ? bottom_reg - pad_by : top_reg + pad_by;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            grid_reg  <= '0;
        end
        else if (cfg_write)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE: ;
                ST_LOAD: state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (!div_w_busy && !div_h_busy)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    grid_reg  <= grid_next;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assign grid = grid_reg;
    assign busy = state_reg != ST_IDLE;

endmodule

// ===== hdl/rtcr_pipe.sv =====
// ----------------------------------------------------------------------------
// rtcr_pipe: three stage cell to rectangle datapath
// grid check and offsets, far corners, rotation and output register
// ----------------------------------------------------------------------------
module rtcr_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  rtcr_pkg::grid_t    grid,
    input  logic               hold,
    input  logic               in_valid,
    output logic               in_ready,
    input  rtcr_pkg::idx_t     cell_row,
    input  rtcr_pkg::idx_t     cell_col,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               in_grid,
    output rtcr_pkg::coord_t   rect_x0,
    output rtcr_pkg::coord_t   rect_y0,
    output rtcr_pkg::coord_t   rect_x1,
    output rtcr_pkg::coord_t   rect_y1
);

    logic             rdy1;
    logic             rdy2;
    logic             rdy3;
    logic             take;

    // stage 1
    logic             v1_reg;
    logic             ig1_reg;
    rtcr_pkg::coord_t ax0_1_reg;
    rtcr_pkg::coord_t ay0_1_reg;
    rtcr_pkg::idx_t   idx_a;
    rtcr_pkg::idx_t   idx_b;
    rtcr_pkg::prod_t  prod_a;
    rtcr_pkg::prod_t  prod_b;
    logic             ig_next;

    // stage 2
    logic             v2_reg;
    logic             ig2_reg;
    rtcr_pkg::coord_t ax0_reg;
    rtcr_pkg::coord_t ax1_reg;
    rtcr_pkg::coord_t ay0_reg;
    rtcr_pkg::coord_t ay1_reg;

    // stage 3
    logic             v3_reg;
    logic             ig3_reg;
    rtcr_pkg::coord_t x0_reg;
    rtcr_pkg::coord_t y0_reg;
    rtcr_pkg::coord_t x1_reg;
    rtcr_pkg::coord_t y1_reg;
    rtcr_pkg::coord_t x0_next;
    rtcr_pkg::coord_t y0_next;
    rtcr_pkg::coord_t x1_next;
    rtcr_pkg::coord_t y1_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1 && !hold;
    assign take     = in_valid && in_ready;

    // stage 1: bounds check and cell offsets along the display axes
    assign idx_a   = grid.swap ? cell_row : cell_col;
    assign idx_b   = grid.swap ? cell_col : cell_row;
    assign prod_a  = rtcr_pkg::PROD_BITS'(idx_a) * rtcr_pkg::PROD_BITS'(grid.step_x);
    assign prod_b  = rtcr_pkg::PROD_BITS'(idx_b) * rtcr_pkg::PROD_BITS'(grid.step_y);
    assign ig_next = (rtcr_pkg::CMP_BITS'(cell_row) < rtcr_pkg::CMP_BITS'(grid.rows)) &&
                     (rtcr_pkg::CMP_BITS'(cell_col) < rtcr_pkg::CMP_BITS'(grid.cols));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= take;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ig1_reg   <= ig_next;
            ax0_1_reg <= prod_a[rtcr_pkg::COORD_BITS-1:0];
            ay0_1_reg <= prod_b[rtcr_pkg::COORD_BITS-1:0];
        end
    end

    // stage 2: far corners of the unrotated cell
    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            ig2_reg <= ig1_reg;
            ax0_reg <= ax0_1_reg;
            ay0_reg <= ay0_1_reg;
            ax1_reg <= ax0_1_reg + rtcr_pkg::COORD_BITS'(grid.step_x);
            ay1_reg <= ay0_1_reg + rtcr_pkg::COORD_BITS'(grid.step_y);
        end
    end

    // stage 3: mirror against the far bound where the turn needs it
    always_comb
    begin
        x0_next = grid.flip_x ? grid.base_x - ax1_reg : grid.base_x + ax0_reg;
        x1_next = grid.flip_x ? grid.base_x - ax0_reg : grid.base_x + ax1_reg;
        y0_next = grid.flip_y ? grid.base_y - ay1_reg : grid.base_y + ay0_reg;
        y1_next = grid.flip_y ? grid.base_y - ay0_reg : grid.base_y + ay1_reg;
        if (!ig2_reg)
        begin
            x0_next = '0;
            x1_next = '0;
            y0_next = '0;
            y1_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            ig3_reg <= ig2_reg;
            x0_reg  <= x0_next;
            y0_reg  <= y0_next;
            x1_reg  <= x1_next;
            y1_reg  <= y1_next;
        end
    end

    assign out_valid = v3_reg;
    assign in_grid   = ig3_reg;
    assign rect_x0   = x0_reg;
    assign rect_y0   = y0_reg;
    assign rect_x1   = x1_reg;
    assign rect_y1   = y1_reg;

endmodule

// ===== hdl/rotated_text_cell_rect.sv =====
// a word passes the stage 1, 2 and 3 registers to out_valid; low out_ready holds it
// throughput: one word per cycle, set by the three stage datapath, while not stalled
// grid unit: after reset and after every register write the two dividers run
// one quotient bit per cycle, and in_ready stays low until the grid unit is idle
// reset: rst_n asynchronous active low, registers take their reset values and the
// pipeline empties; configuration writes are taken in every cycle
// ----------------------------------------------------------------------------
// rotated_text_cell_rect: text cell to pixel rectangle mapper
// maps (row, column) of a text grid to its rectangle on a turned display
// ----------------------------------------------------------------------------
module rotated_text_cell_rect (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rtcr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [rtcr_pkg::CFG_DATA_BITS-1:0]    cfg_data,

    // cell word in
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  rtcr_pkg::idx_t                        cell_row,
    input  rtcr_pkg::idx_t                        cell_col,

    // rectangle word out
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  in_grid,
    output rtcr_pkg::coord_t                      rect_x0,
    output rtcr_pkg::coord_t                      rect_y0,
    output rtcr_pkg::coord_t                      rect_x1,
    output rtcr_pkg::coord_t                      rect_y1
);

    rtcr_pkg::grid_t grid;
    logic            grid_busy;
    logic            cfg_write;

    // registers are always writable, a write restarts the grid unit
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // registers, extent clamp and swap, column and row counts by division,
    // centring pads and the corner base for each axis
    rtcr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .grid      (grid),
        .busy      (grid_busy)
    );

    // per cell datapath, held off while the grid geometry is recomputed
    rtcr_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid      (grid),
        .hold      (grid_busy),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .in_grid   (in_grid),
        .rect_x0   (rect_x0),
        .rect_y0   (rect_y0),
        .rect_x1   (rect_x1),
        .rect_y1   (rect_y1)
    );

    // no cell word is taken while the geometry is stale
    a_hold_while_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        grid_busy |-> !in_ready
    ) else $error("cell word taken while grid unit busy");

    // a register write closes the input on the next cycle
    a_write_closes_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        cfg_write |=> !in_ready
    ) else $error("input open right after register write");

    // cells outside the grid give an all-zero rectangle
    a_outside_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !in_grid) |->
            (rect_x0 == '0 && rect_y0 == '0 && rect_x1 == '0 && rect_y1 == '0)
    ) else $error("non-zero rectangle for cell outside grid");

endmodule

// ===== verif/tb_rotated_text_cell_rect.sv =====
// ----------------------------------------------------------------------------
// tb_rotated_text_cell_rect: self-checking bench for the rotated cell mapper
// programs the display geometry while the block is idle, streams (row, column)
// words through it with random idling on both sides and compares every
// rectangle word against a behavioural model of the grid maths
// ----------------------------------------------------------------------------
module tb_rotated_text_cell_rect;

    timeunit 1ns;
    timeprecision 1ps;

    import rtcr_pkg::*;

    typedef logic [CFG_DATA_BITS-1:0] cfg_word_t;

    // pending register write
    typedef struct packed {
        logic [CFG_IDX_BITS-1:0] idx;
        cfg_word_t               data;
    } reg_write_t;

    // pending cell word
    typedef struct packed {
        idx_t row;
        idx_t col;
    } cell_word_t;

    // expected rectangle word, tagged with the cell that caused it
    typedef struct packed {
        idx_t   row;
        idx_t   col;
        logic   in_grid;
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
    } cell_rect_t;

    // grid geometry as the block derives it from the registers
    typedef struct {
        int cols;
        int rows;
        int pad_x;
        int pad_y;
    } grid_dims_t;

    // index 7 decodes to no register, writes there must change nothing
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 3'd7;

    localparam coord_t COORD_MAX    = '1;
    localparam idx_t   IDX_MAX      = '1;
    localparam size_t  SIZE_MAX     = '1;
    localparam int     RUN_ITEMS    = 620;
    localparam int     QUIET_ITEMS  = 120;
    localparam int     TAIL_CYCLES  = 20;
    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     MAX_REPORTS  = 100;

    logic      clk;
    logic      rst_n     = 1'b0;

    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    cfg_word_t cfg_data  = '0;

    logic      in_valid  = 1'b0;
    logic      in_ready;
    idx_t      cell_row  = '0;
    idx_t      cell_col  = '0;

    logic      out_valid;
    logic      out_ready = 1'b0;
    logic      in_grid;
    coord_t    rect_x0;
    coord_t    rect_y0;
    coord_t    rect_x1;
    coord_t    rect_y1;

    // model copy of the register file, reset values as in the block
    coord_t    bnd_left   = '0;
    coord_t    bnd_top    = '0;
    coord_t    bnd_right  = '0;
    coord_t    bnd_bottom = '0;
    size_t     cell_w     = CELL_WIDTH_RESET;
    size_t     cell_h     = CELL_HEIGHT_RESET;
    orient_t   turn       = ROT_0;

    reg_write_t reg_q[$];      // register writes waiting for the config channel
    cell_word_t cell_q[$];     // cell words waiting for the input channel
    cell_rect_t rect_q[$];     // rectangles the block still owes us

    int        error_count = 0;
    int        sent_count  = 0;
    int        in_gap      = 0;
    int        out_gap     = 0;
    bit        idle_on     = 1'b1;

    rotated_text_cell_rect i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .in_grid   (in_grid),
        .rect_x0   (rect_x0),
        .rect_y0   (rect_y0),
        .rect_x1   (rect_x1),
        .rect_y1   (rect_y1)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // grid model
    // ------------------------------------------------------------------

    // register write as the block takes it, data masked to the register width
    task automatic apply_reg(logic [CFG_IDX_BITS-1:0] idx, cfg_word_t data);
        case (idx)
            REG_BOUND_LEFT:   bnd_left   = data[COORD_BITS-1:0];
            REG_BOUND_TOP:    bnd_top    = data[COORD_BITS-1:0];
            REG_BOUND_RIGHT:  bnd_right  = data[COORD_BITS-1:0];
            REG_BOUND_BOTTOM: bnd_bottom = data[COORD_BITS-1:0];
            REG_CELL_WIDTH:   cell_w     = data[SIZE_BITS-1:0];
            REG_CELL_HEIGHT:  cell_h     = data[SIZE_BITS-1:0];
            REG_ORIENTATION:  turn       = orient_t'(data[ORIENT_BITS-1:0]);
            default:          ;
        endcase
    endtask

    // logical extent clamped at zero, swapped on quarter and three-quarter
    // turns, then column and row counts and the centring pads
    function automatic grid_dims_t derive_grid();
        grid_dims_t g;
        int ext_w;
        int ext_h;
        int w;
        int h;
        ext_w = (bnd_right > bnd_left) ? int'(bnd_right) - int'(bnd_left) : 0;
        ext_h = (bnd_bottom > bnd_top) ? int'(bnd_bottom) - int'(bnd_top) : 0;
        w = turn[0] ? ext_h : ext_w;
        h = turn[0] ? ext_w : ext_h;
        // a zero cell size gives an empty grid, no division
        g.cols  = (cell_w != 0) ? w / int'(cell_w) : 0;
        g.rows  = (cell_h != 0) ? h / int'(cell_h) : 0;
        g.pad_x = (w - int'(cell_w) * g.cols) / 2;
        g.pad_y = (h - int'(cell_h) * g.rows) / 2;
        return g;
    endfunction

    function automatic cell_rect_t predict_rect(idx_t row, idx_t col);
        cell_rect_t res;
        grid_dims_t g;
        int ux0, ux1, uy0, uy1;
        int x0, y0, x1, y1;
        g = derive_grid();
        res = '0;
        res.row = row;
        res.col = col;
        // outside the grid every corner reads as zero
        if (int'(row) >= g.rows || int'(col) >= g.cols)
            return res;
        ux0 = int'(col) * int'(cell_w);
        ux1 = ux0 + int'(cell_w);
        uy0 = int'(row) * int'(cell_h);
        uy1 = uy0 + int'(cell_h);
        case (turn)
            ROT_90:
            begin
                x0 = int'(bnd_left) + g.pad_y + uy0;
                y0 = int'(bnd_bottom) - g.pad_x - ux1;
                x1 = int'(bnd_left) + g.pad_y + uy1;
                y1 = int'(bnd_bottom) - g.pad_x - ux0;
            end
            ROT_180:
            begin
                x0 = int'(bnd_right) - g.pad_x - ux1;
                y0 = int'(bnd_bottom) - g.pad_y - uy1;
                x1 = int'(bnd_right) - g.pad_x - ux0;
                y1 = int'(bnd_bottom) - g.pad_y - uy0;
            end
            ROT_270:
            begin
                x0 = int'(bnd_right) - g.pad_y - uy1;
                y0 = int'(bnd_top) + g.pad_x + ux0;
                x1 = int'(bnd_right) - g.pad_y - uy0;
                y1 = int'(bnd_top) + g.pad_x + ux1;
            end
            default:
            begin
                x0 = int'(bnd_left) + g.pad_x + ux0;
                y0 = int'(bnd_top) + g.pad_y + uy0;
                x1 = int'(bnd_left) + g.pad_x + ux1;
                y1 = int'(bnd_top) + g.pad_y + uy1;
            end
        endcase
        res.in_grid = 1'b1;
        res.x0 = coord_t'(x0);
        res.y0 = coord_t'(y0);
        res.x1 = coord_t'(x1);
        res.y1 = coord_t'(y1);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // config channel driver: one write per handshake, model updated on accept
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : reg_driver
        reg_write_t nxt;
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_q.size() != 0)
                begin
                    nxt = reg_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= nxt.idx;
                    cfg_data  <= nxt.data;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // cell word driver: valid held until accepted, random idle bursts
    // between words; the expected rectangle is worked out on accept
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : cell_driver
        cell_word_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cell_row <= '0;
            cell_col <= '0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                rect_q.push_back(predict_rect(cell_row, cell_col));
            if (!in_valid || in_ready)
            begin
                if (in_gap != 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (cell_q.size() != 0)
                begin
                    nxt = cell_q.pop_front();
                    in_valid <= 1'b1;
                    cell_row <= nxt.row;
                    cell_col <= nxt.col;
                    // idle burst after this word
                    if (idle_on && $urandom_range(0, 3) == 0)
                        in_gap <= $urandom_range(1, 7);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // rectangle monitor: compares each accepted word with the oldest
    // expectation and stalls the output in random bursts
    // ------------------------------------------------------------------
    task automatic check_field(string field, idx_t row, idx_t col, int expv, int actv);
        if (expv != actv)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t ns: %s of cell (%0d, %0d) expected %0d actual %0d",
                         $time, field, row, col, expv, actv);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : rect_monitor
        cell_rect_t exp_w;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (rect_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: rectangle word with nothing expected", $time);
                end
                else
                begin
                    exp_w = rect_q.pop_front();
                    check_field("in_grid", exp_w.row, exp_w.col, exp_w.in_grid, in_grid);
                    check_field("rect_x0", exp_w.row, exp_w.col, exp_w.x0, rect_x0);
                    check_field("rect_y0", exp_w.row, exp_w.col, exp_w.y0, rect_y0);
                    check_field("rect_x1", exp_w.row, exp_w.col, exp_w.x1, rect_x1);
                    check_field("rect_y1", exp_w.row, exp_w.col, exp_w.y1, rect_y1);
                end
            end
            if (out_gap != 0)
            begin
                out_gap   <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0)
                    out_gap <= $urandom_range(1, 7);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, cfg_word_t data);
        reg_write_t w;
        w.idx  = idx;
        w.data = data;
        reg_q.push_back(w);
    endtask

    task automatic send_cell(int row, int col);
        cell_word_t w;
        w.row = idx_t'(row);
        w.col = idx_t'(col);
        cell_q.push_back(w);
        sent_count++;
    endtask

    // full geometry; the unused upper data bits of the narrow registers
    // carry noise that the block has to drop
    task automatic set_geometry(int l, int t, int r, int b, size_t cw, size_t ch,
                                orient_t o);
        cfg_word_t d;
        write_reg(REG_BOUND_LEFT,   cfg_word_t'(l));
        write_reg(REG_BOUND_TOP,    cfg_word_t'(t));
        write_reg(REG_BOUND_RIGHT,  cfg_word_t'(r));
        write_reg(REG_BOUND_BOTTOM, cfg_word_t'(b));
        d = cfg_word_t'($urandom);
        d[SIZE_BITS-1:0] = cw;
        write_reg(REG_CELL_WIDTH, d);
        d = cfg_word_t'($urandom);
        d[SIZE_BITS-1:0] = ch;
        write_reg(REG_CELL_HEIGHT, d);
        d = cfg_word_t'($urandom);
        d[ORIENT_BITS-1:0] = o;
        write_reg(REG_ORIENTATION, d);
    endtask

    // wait at a falling edge until every queued write and word has gone and
    // every expected rectangle has come back
    task automatic drain();
        do
            @(negedge clk);
        while (reg_q.size() != 0 || cfg_valid || cell_q.size() != 0 || in_valid ||
               rect_q.size() != 0);
    endtask

    // mostly moderate sizes, now and then the extremes and the empty case
    function automatic size_t pick_cell_size();
        int p;
        p = $urandom_range(0, 19);
        if (p == 0)
            return '0;
        else if (p < 3)
            return SIZE_MAX;
        else if (p < 5)
            return size_t'(1);
        return size_t'($urandom_range(1, 48));
    endfunction

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        grid_dims_t g;
        orient_t    turns[3];
        int         n;
        int         pick;
        int         l, t, r, b;

        turns = '{ROT_90, ROT_180, ROT_270};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // grid unit recalculates after reset, words simply wait on in_ready
        drain();

        // reset geometry has an empty area, nothing lies in the grid
        send_cell(0, 0);
        send_cell(IDX_MAX, IDX_MAX);
        drain();

        // whole coordinate space, one-pixel cells: largest grid, all corners
        set_geometry(0, 0, COORD_MAX, COORD_MAX, 1, 1, ROT_0);
        drain();
        send_cell(0, 0);
        send_cell(IDX_MAX - 1, IDX_MAX - 1);
        send_cell(IDX_MAX, 0);
        send_cell(0, IDX_MAX);
        drain();

        // every other orientation on the same grid
        foreach (turns[i])
        begin
            write_reg(REG_ORIENTATION, cfg_word_t'(turns[i]));
            drain();
            send_cell(0, 0);
            send_cell(IDX_MAX - 1, IDX_MAX - 1);
            drain();
        end

        // largest cells: last cell inside and first row past the edge
        set_geometry(0, 0, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, ROT_180);
        drain();
        g = derive_grid();
        send_cell(g.rows - 1, g.cols - 1);
        send_cell(g.rows, 0);
        drain();

        // inverted bounds clamp to an empty area; spare index must be ignored
        set_geometry(100, 200, 50, 150, 8, 16, ROT_270);
        write_reg(CFG_IDX_SPARE, '1);
        drain();
        send_cell(0, 0);
        drain();

        // zero cell width, then zero cell height
        set_geometry(0, 0, COORD_MAX, COORD_MAX, 0, 16, ROT_0);
        drain();
        send_cell(0, 0);
        drain();
        write_reg(REG_CELL_WIDTH, cfg_word_t'(8));
        write_reg(REG_CELL_HEIGHT, '0);
        drain();
        send_cell(0, 0);
        drain();

        // random geometries, each followed by a burst of cell words; the
        // last stretch of the run goes without any idling
        while (sent_count < RUN_ITEMS)
        begin
            idle_on = (sent_count < RUN_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // right of left inverted, vertical extent random
                l = $urandom_range(1, COORD_MAX);
                r = $urandom_range(0, l - 1);
                t = $urandom_range(0, COORD_MAX);
                b = $urandom_range(0, COORD_MAX);
            end
            else if (pick == 1)
            begin
                l = 0;
                t = 0;
                r = COORD_MAX;
                b = COORD_MAX;
            end
            else
            begin
                l = $urandom_range(0, 2047);
                r = l + $urandom_range(0, COORD_MAX - l);
                t = $urandom_range(0, 2047);
                b = t + $urandom_range(0, COORD_MAX - t);
            end
            set_geometry(l, t, r, b, pick_cell_size(), pick_cell_size(),
                         orient_t'($urandom_range(0, 3)));
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_IDX_SPARE, cfg_word_t'($urandom));
            drain();

            g = derive_grid();
            n = (g.rows == 0 || g.cols == 0) ? $urandom_range(3, 8) : $urandom_range(20, 60);
            repeat (n)
            begin
                pick = $urandom_range(0, 9);
                if (g.rows > 0 && g.cols > 0 && pick < 7)
                    send_cell($urandom_range(0, g.rows - 1), $urandom_range(0, g.cols - 1));
                else if (g.rows > 0 && g.cols > 0 && pick < 9)
                    // straddle the far edges of the grid
                    send_cell(g.rows - int'($urandom_range(0, 1)),
                              g.cols - int'($urandom_range(0, 1)));
                else
                    send_cell($urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX));
            end
            drain();
        end

        // let any stray word surface before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && rect_q.size() == 0)
            $display("PASS rotated_text_cell_rect");
        else
            $display("FAIL rotated_text_cell_rect");
        $finish;
    end

    // watchdog against a hung handshake
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL rotated_text_cell_rect");
        $finish;
    end

endmodule
